// ----- design/assert_macros.svh -----
// Assertion macros used by the top-level RTL file of the sorted read-mark list.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property must hold on every clock edge outside reset.
`define SRML_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("srml assertion failed");

// Condition must never be seen outside reset.
`define SRML_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("srml forbidden condition seen");

`else

`define SRML_ASSERT(lbl, clk, rstn, prop)
`define SRML_NEVER(lbl, clk, rstn, cond)

`endif

`endif

// ----- design/srml_pkg.sv -----
// Types and constants of the sorted read-mark list.
`default_nettype none

package srml_pkg;

  localparam int LIST_DEPTH    = 64;
  localparam int STAMP_W       = 31;
  localparam int CNT_W         = $clog2(LIST_DEPTH + 1);
  localparam int POS_W         = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int ENTRY_COUNT_W = 7;

  localparam logic [STAMP_W-1:0] DEFAULT_STAMP = STAMP_W'(1);
  localparam logic [CNT_W-1:0]   DEFAULT_COUNT = CNT_W'(1);
  localparam logic [CNT_W-1:0]   FULL_COUNT    = CNT_W'(LIST_DEPTH);

  typedef enum logic [1:0] {
    ACT_QUERY   = 2'd0,
    ACT_ADD     = 2'd1,
    ACT_CLEAR   = 2'd2,
    ACT_RESTART = 2'd3
  } action_t;

  // Command broadcast to every cell of the row
  typedef struct packed {
    logic                en;
    action_t             action;
    logic [STAMP_W-1:0]  stamp;
    logic                unread;
  } cmd_t;

  // What one cell hands to its right-hand neighbour
  typedef struct packed {
    logic                ge;
    logic [STAMP_W-1:0]  entry;
  } link_t;

  // Row summary for the current stamp
  typedef struct packed {
    logic                found;
    logic                any_ge;
    logic [POS_W-1:0]    pos;
  } row_stat_t;

endpackage

`default_nettype wire

// ----- design/srml_cell.sv -----
// One list cell: holds an entry and its valid bit, compares and shifts.
`default_nettype none

module srml_cell
  import srml_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  is_head,
  input  wire cmd_t  cmd,
  input  wire link_t prev,
  output link_t      link,
  output logic       valid,
  output logic       eq,
  output logic       at_pos
);

  logic [STAMP_W-1:0] entry_r, entry_nxt;
  logic               valid_r, valid_nxt;
  logic               ge;

  // Entry not newer than the stamp; list order makes this monotonic along the row
  assign ge     = valid_r && (entry_r <= cmd.stamp);
  assign eq     = valid_r && (entry_r == cmd.stamp);
  assign at_pos = ge && !prev.ge;

  assign link.ge    = ge;
  assign link.entry = entry_r;
  assign valid      = valid_r;

  always_comb begin
    entry_nxt = entry_r;
    valid_nxt = valid_r;
    if (cmd.en) begin
      unique case (cmd.action)
        ACT_QUERY: begin
        end
        ACT_ADD: begin
          if (cmd.unread) begin
            if (at_pos) begin
              entry_nxt = cmd.stamp;
            end else if (prev.ge) begin
              entry_nxt = prev.entry;
            end
            valid_nxt = valid_r || prev.ge;
          end
        end
        ACT_CLEAR: begin
          if (at_pos) begin
            entry_nxt = cmd.stamp;
          end
          valid_nxt = valid_r && !prev.ge;
        end
        ACT_RESTART: begin
          entry_nxt = DEFAULT_STAMP;
          valid_nxt = is_head;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= DEFAULT_STAMP;
      valid_r <= is_head;
    end else begin
      entry_r <= entry_nxt;
      valid_r <= valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/srml_row.sv -----
// Row of list cells with the found / position summary.
`default_nettype none

module srml_row
  import srml_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cmd_t              cmd,
  output row_stat_t              stat,
  output logic [LIST_DEPTH-1:0]  valid_vec
);

  link_t                 links [LIST_DEPTH+1];
  logic [LIST_DEPTH-1:0] eq_vec;
  logic [LIST_DEPTH-1:0] pos_vec;
  logic [LIST_DEPTH-1:0] ge_vec;
  logic [POS_W-1:0]      pos_enc;

  assign links[0] = '{ge: 1'b0, entry: '0};

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    srml_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .is_head (i == 0),
      .cmd     (cmd),
      .prev    (links[i]),
      .link    (links[i+1]),
      .valid   (valid_vec[i]),
      .eq      (eq_vec[i]),
      .at_pos  (pos_vec[i])
    );
    assign ge_vec[i] = links[i+1].ge;
  end

  // pos_vec is one-hot or empty, so the index is an OR of the set positions
  always_comb begin
    pos_enc = '0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      if (pos_vec[i]) begin
        pos_enc = pos_enc | POS_W'(i);
      end
    end
  end

  assign stat = '{found: |eq_vec, any_ge: |ge_vec, pos: pos_enc};

endmodule

`default_nettype wire

// ----- design/sorted_read_mark_list.sv -----
// Top level of the sorted read-mark list: handshake, count, change flag and result register.
`default_nettype none

// Keeps a strictly descending list of up to 64 timestamps marking what has been
// seen; anything older than the last entry also counts as seen. Each input
// transaction carries an action (query, add if unseen, clear to stamp, restart)
// in in_tuser and a stamp in in_tdata, and yields exactly one result transaction
// with the unseen flag, the entry count after the step and the change flag.
// One transaction is accepted per clock cycle while out_tready or an empty output
// register allows it; its result appears in the output register on the following
// cycle. The cycle is bounded by the row of 64 compare cells, which all test the
// stamp in parallel and shift into their right-hand neighbours, followed by the one-hot
// position encode. Reset sets the list to the single entry 1 at once; no clearing pass.

`include "assert_macros.svh"

module sorted_read_mark_list
  import srml_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [30:0] stamp
  input  wire logic [1:0]  in_tuser,   // [1:0] action
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata   // [0] was_unread, [7:1] entry_count, [8] modified
);

  cmd_t                  cmd;
  row_stat_t             stat;
  logic [LIST_DEPTH-1:0] valid_vec;
  logic                  accept;
  logic                  unread;

  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  dirty_r, dirty_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [15:0]           out_data_r;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  assign unread = !stat.found && stat.any_ge;

  assign cmd.en     = accept;
  assign cmd.action = action_t'(in_tuser);
  assign cmd.stamp  = in_tdata[STAMP_W-1:0];
  assign cmd.unread = unread;

  srml_row u_row (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .valid_vec (valid_vec)
  );

  always_comb begin
    count_nxt = count_r;
    dirty_nxt = dirty_r;
    unique case (cmd.action)
      ACT_QUERY: begin
      end
      ACT_ADD: begin
        if (unread) begin
          dirty_nxt = 1'b1;
          if (count_r != FULL_COUNT) begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
      end
      ACT_CLEAR: begin
        if (stat.any_ge) begin
          dirty_nxt = 1'b1;
          count_nxt = CNT_W'(stat.pos) + CNT_W'(1);
        end
      end
      ACT_RESTART: begin
        dirty_nxt = 1'b0;
        count_nxt = DEFAULT_COUNT;
      end
      default: begin
      end
    endcase
  end

  assign out_valid_nxt = accept || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= DEFAULT_COUNT;
      dirty_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        count_r <= count_nxt;
        dirty_r <= dirty_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= {7'd0, dirty_nxt, ENTRY_COUNT_W'(count_nxt), unread};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Count register tracks the number of valid cells
  `SRML_ASSERT(a_count_matches_cells, clk, rst_n, $countones(valid_vec) == count_r)
  // The head cell is always valid
  `SRML_ASSERT(a_head_valid, clk, rst_n, valid_vec[0])
  // A restart leaves one clean entry
  `SRML_ASSERT(a_restart, clk, rst_n,
    (accept && cmd.action == ACT_RESTART) |=> (count_r == DEFAULT_COUNT && !dirty_r))
  // A stamp found in the list is never reported as unseen
  `SRML_NEVER(a_found_unread, clk, rst_n, stat.found && unread)

endmodule

`default_nettype wire
